// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dct_pkg.sv
// shared widths, register indexes and outcome codes of the decayed count table
`default_nettype none

package dct_pkg;

    localparam int SLOT_W     = 10;
    localparam int CLICK_W    = 32;
    localparam int STEP_W     = 48;
    localparam int EPOCH_W    = 48;
    localparam int DATA_W     = 48;
    localparam int OUTCOME_W  = 2;
    localparam int FACTOR_W   = 17;
    localparam int PERIOD_W   = 32;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = DATA_W + 2;
    localparam int RAM_W      = DATA_W + EPOCH_W + 1;

    localparam int ENTRIES_DEFAULT = 1024;

    // shared multiplier: 24 x 17 bits
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = FACTOR_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SCALE_W    = MUL_P_W + MUL_A_W;

    localparam int Q16_BITS   = 16;
    localparam int Q16_HALF   = 1 << (Q16_BITS - 1);
    localparam logic [FACTOR_W-1:0] DECAY_ONE = FACTOR_W'(1 << Q16_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_EPOCH  = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_UPDATED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_STALE   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_ABSENT  = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_SAT     = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/dct_in_if.sv
// input channel: one update word per handshake
`default_nettype none

interface dct_in_if import dct_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot_index;
    logic                id_absent;
    logic [CLICK_W-1:0]  click_count;
    logic [STEP_W-1:0]   train_step;

    modport source (output valid, output slot_index, output id_absent,
                    output click_count, output train_step, input ready);
    modport sink   (input valid, input slot_index, input id_absent,
                    input click_count, input train_step, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/dct_out_if.sv
// result channel: one result word per handshake
`default_nettype none

interface dct_out_if import dct_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    entry_result;
    logic [OUTCOME_W-1:0] outcome;

    modport source (output valid, output entry_result, output outcome, input ready);
    modport sink   (input valid, input entry_result, input outcome, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/dct_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module dct_ram import dct_pkg::*; #(
    parameter int WIDTH = RAM_W,
    parameter int DEPTH = ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/decayed_count_table.sv
// top level of the decayed count table
//
//   channel   direction  handshake      word
//   cmd       in         valid/ready    slot_index, id_absent, click_count, train_step
//   rsp       out        valid/ready    entry_result, outcome
//   cfg       in         cfg_wr_en      cfg_index, cfg_wr_data
//
// one word at a time: slot taken modulo ENTRIES by a constant reciprocal multiply at
// accept, epoch division on the restoring divider (S_DIV), compare (S_CMP), then the
// power over the epoch-gap bits on the shared 24x17 multiplier (S_PW_A/B/C), scale
// (S_SC_LO/HI/SUM/NEG), add (S_ADD) and hand-off; absent/stale words skip to hand-off
// after reset a clearing pass sweeps every table ram entry, cmd not ready
// rsp is a holding register: the next cmd word is taken while a result waits
`default_nettype none

module decayed_count_table import dct_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    dct_in_if.sink                cmd,
    dct_out_if.source             rsp
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(STEP_W);
    localparam int RED_K   = SLOT_W + 16;
    localparam int RED_P_W = SLOT_W + RED_K;
    localparam longint unsigned RED_M =
        ((64'd1 << RED_K) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);

    typedef enum logic [11:0] {
        S_CLR    = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_DIV    = 12'b000000000100,
        S_CMP    = 12'b000000001000,
        S_PW_A   = 12'b000000010000,
        S_PW_B   = 12'b000000100000,
        S_PW_C   = 12'b000001000000,
        S_SC_LO  = 12'b000010000000,
        S_SC_HI  = 12'b000100000000,
        S_SC_SUM = 12'b001000000000,
        S_SC_NEG = 12'b010000000000,
        S_ADD    = 12'b100000000000
    } state_t;

    // finishing state kept apart so the enum stays one-hot over all steps
    typedef enum logic {
        FIN_OFF = 1'b0,
        FIN_ON  = 1'b1
    } fin_t;

    state_t               state_reg, state_next;
    fin_t                 fin_reg, fin_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [FACTOR_W-1:0]  decay_factor_reg;
    logic [PERIOD_W-1:0]  decay_period_reg;
    logic [EPOCH_W-1:0]   start_epoch_reg;

    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 absent_reg, absent_next;
    logic [CLICK_W-1:0]   click_reg, click_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [PERIOD_W-1:0]  div_rem_reg, div_rem_next;
    logic [STEP_W-1:0]    div_q_reg, div_q_next;
    logic [PERIOD_W-1:0]  divisor_reg, divisor_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [EPOCH_W-1:0]   gap_reg, gap_next;
    logic [FACTOR_W-1:0]  acc_reg, acc_next;
    logic [FACTOR_W-1:0]  base_reg, base_next;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_P_W-1:0]   lo_prod_reg, lo_prod_next;
    logic [DATA_W-1:0]    mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [DATA_W-1:0]    result_reg, result_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;
    logic                 upd_reg, upd_next;
    logic [DATA_W-1:0]    rsp_result_reg, rsp_result_next;
    logic [OUTCOME_W-1:0] rsp_outcome_reg, rsp_outcome_next;

    // slot modulo ENTRIES by reciprocal multiply
    logic [RED_P_W-1:0]   red_prod;
    logic [SLOT_W-1:0]    red_q;
    logic [SLOT_W-1:0]    red_rem;

    // divider step
    logic [PERIOD_W:0]    div_shift;
    logic [PERIOD_W:0]    div_sub;
    logic                 div_ge;
    logic [PERIOD_W-1:0]  rem_step;
    logic [STEP_W-1:0]    q_step;

    // shared multiplier
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [MUL_P_W-1:0]   rnd_sum;
    logic [FACTOR_W-1:0]  rnd_q16;
    logic [SCALE_W-1:0]   scale_sum;

    // add and saturate
    logic [SUM_W-1:0]     click_ext;
    logic [SUM_W-1:0]     sum_full;
    logic                 sum_ovf;

    // table ram
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [RAM_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]    rd_value;
    logic [EPOCH_W-1:0]   rd_epoch;
    logic                 rd_touched;
    logic [EPOCH_W-1:0]   stored_epoch;
    logic [EPOCH_W-1:0]   epoch_gap;
    logic [FACTOR_W-1:0]  decay_clamped;

    dct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_dct_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    assign red_prod  = RED_P_W'(cmd.slot_index) * RED_P_W'(RED_M);
    assign red_q     = red_prod[RED_K +: SLOT_W];
    assign red_rem   = cmd.slot_index - red_q * SLOT_W'(ENTRIES);

    assign div_shift = {div_rem_reg, div_q_reg[STEP_W-1]};
    assign div_sub   = div_shift - {1'b0, divisor_reg};
    assign div_ge    = div_shift >= {1'b0, divisor_reg};
    assign rem_step  = div_ge ? div_sub[PERIOD_W-1:0] : div_shift[PERIOD_W-1:0];
    assign q_step    = {div_q_reg[STEP_W-2:0], div_ge};

    assign mul_p     = mul_a * mul_b;
    assign rnd_sum   = prod_reg + MUL_P_W'(Q16_HALF);
    assign rnd_q16   = rnd_sum[Q16_BITS +: FACTOR_W];
    assign scale_sum = {prod_reg, {MUL_A_W{1'b0}}} + {{MUL_A_W{1'b0}}, lo_prod_reg}
                       + SCALE_W'(Q16_HALF);

    assign click_ext = {{(SUM_W-CLICK_W-FRAC_BITS){click_reg[CLICK_W-1]}}, click_reg,
                        {FRAC_BITS{1'b0}}};
    assign sum_full  = {{(SUM_W-DATA_W){value_reg[DATA_W-1]}}, value_reg} + click_ext;
    assign sum_ovf   = !((sum_full[SUM_W-1:DATA_W-1] == '0)
                        || (sum_full[SUM_W-1:DATA_W-1] == '1));

    assign rd_value      = ram_rdata[DATA_W-1:0];
    assign rd_epoch      = ram_rdata[DATA_W +: EPOCH_W];
    assign rd_touched    = ram_rdata[RAM_W-1];
    assign stored_epoch  = rd_touched ? rd_epoch : start_epoch_reg;
    assign epoch_gap     = epoch_reg - stored_epoch;
    assign decay_clamped = (decay_factor_reg > DECAY_ONE) ? DECAY_ONE : decay_factor_reg;

    assign cmd.ready        = (state_reg == S_IDLE) && (fin_reg == FIN_OFF);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.entry_result = rsp_result_reg;
    assign rsp.outcome      = rsp_outcome_reg;

    always_comb
    begin
        state_next       = state_reg;
        fin_next         = fin_reg;
        clr_addr_next    = clr_addr_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_result_next  = rsp_result_reg;
        rsp_outcome_next = rsp_outcome_reg;
        slot_next        = slot_reg;
        absent_next      = absent_reg;
        click_next       = click_reg;
        epoch_next       = epoch_reg;
        div_rem_next     = div_rem_reg;
        div_q_next       = div_q_reg;
        divisor_next     = divisor_reg;
        div_cnt_next     = div_cnt_reg;
        gap_next         = gap_reg;
        acc_next         = acc_reg;
        base_next        = base_reg;
        lo_prod_next     = lo_prod_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        value_next       = value_reg;
        result_next      = result_reg;
        outcome_next     = outcome_reg;
        upd_next         = upd_reg;
        mul_a            = '0;
        mul_b            = '0;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = {1'b1, epoch_reg, result_reg};

        if (fin_reg == FIN_ON)
        begin
            // result waits here until the holding register is free
            if (!rsp_valid_reg || rsp.ready)
            begin
                rsp_valid_next   = 1'b1;
                rsp_result_next  = result_reg;
                rsp_outcome_next = outcome_reg;
                ram_we           = upd_reg;
                fin_next         = FIN_OFF;
                state_next       = S_IDLE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = clr_addr_reg;
                    ram_wdata     = '0;
                    clr_addr_next = clr_addr_reg + 1'b1;
                    if (clr_addr_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        slot_next    = IDX_W'(red_rem);
                        absent_next  = cmd.id_absent;
                        click_next   = cmd.click_count;
                        div_rem_next = '0;
                        div_q_next   = cmd.train_step;
                        divisor_next = (decay_period_reg == '0) ? PERIOD_W'(1)
                                                                : decay_period_reg;
                        div_cnt_next = CNT_W'(STEP_W - 1);
                        state_next   = S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_rem_next = rem_step;
                    div_q_next   = q_step;
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        epoch_next = q_step;
                        state_next = S_CMP;
                    end
                end
                S_CMP:
                begin
                    value_next  = rd_value;
                    result_next = rd_value;
                    neg_next    = rd_value[DATA_W-1];
                    mag_next    = rd_value[DATA_W-1] ? (~rd_value + 1'b1) : rd_value;
                    acc_next    = DECAY_ONE;
                    base_next   = decay_clamped;
                    gap_next    = epoch_gap;
                    upd_next    = 1'b0;
                    if (absent_reg)
                    begin
                        outcome_next = OUT_ABSENT;
                        fin_next     = FIN_ON;
                    end
                    else if (({1'b0, epoch_reg} + 1'b1) < {1'b0, stored_epoch})
                    begin
                        outcome_next = OUT_STALE;
                        fin_next     = FIN_ON;
                    end
                    else if (epoch_reg > stored_epoch)
                    begin
                        state_next = epoch_gap[0] ? S_PW_A : S_PW_B;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
                S_PW_A:
                begin
                    mul_a      = {{(MUL_A_W-FACTOR_W){1'b0}}, acc_reg};
                    mul_b      = base_reg;
                    state_next = S_PW_B;
                end
                S_PW_B:
                begin
                    if (gap_reg[0])
                    begin
                        acc_next = rnd_q16;
                    end
                    mul_a      = {{(MUL_A_W-FACTOR_W){1'b0}}, base_reg};
                    mul_b      = base_reg;
                    state_next = S_PW_C;
                end
                S_PW_C:
                begin
                    base_next = rnd_q16;
                    gap_next  = gap_reg >> 1;
                    if (gap_reg[EPOCH_W-1:1] == '0)
                    begin
                        state_next = S_SC_LO;
                    end
                    else if (gap_reg[1])
                    begin
                        state_next = S_PW_A;
                    end
                    else
                    begin
                        state_next = S_PW_B;
                    end
                end
                S_SC_LO:
                begin
                    mul_a      = mag_reg[MUL_A_W-1:0];
                    mul_b      = acc_reg;
                    state_next = S_SC_HI;
                end
                S_SC_HI:
                begin
                    lo_prod_next = prod_reg;
                    mul_a        = mag_reg[MUL_A_W +: MUL_A_W];
                    mul_b        = acc_reg;
                    state_next   = S_SC_SUM;
                end
                S_SC_SUM:
                begin
                    mag_next   = scale_sum[Q16_BITS +: DATA_W];
                    state_next = S_SC_NEG;
                end
                S_SC_NEG:
                begin
                    value_next = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
                    state_next = S_ADD;
                end
                S_ADD:
                begin
                    upd_next = 1'b1;
                    if (sum_ovf)
                    begin
                        outcome_next = OUT_SAT;
                        result_next  = sum_full[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                         : {1'b0, {(DATA_W-1){1'b1}}};
                    end
                    else
                    begin
                        outcome_next = OUT_UPDATED;
                        result_next  = sum_full[DATA_W-1:0];
                    end
                    fin_next = FIN_ON;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            fin_reg          <= FIN_OFF;
            clr_addr_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            decay_factor_reg <= DECAY_ONE;
            decay_period_reg <= PERIOD_W'(1);
            start_epoch_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_DECAY_FACTOR: decay_factor_reg <= cfg_wr_data[FACTOR_W-1:0];
                    REG_DECAY_PERIOD: decay_period_reg <= cfg_wr_data[PERIOD_W-1:0];
                    REG_START_EPOCH:  start_epoch_reg  <= cfg_wr_data[EPOCH_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        absent_reg      <= absent_next;
        click_reg       <= click_next;
        epoch_reg       <= epoch_next;
        div_rem_reg     <= div_rem_next;
        div_q_reg       <= div_q_next;
        divisor_reg     <= divisor_next;
        div_cnt_reg     <= div_cnt_next;
        gap_reg         <= gap_next;
        acc_reg         <= acc_next;
        base_reg        <= base_next;
        prod_reg        <= mul_p;
        lo_prod_reg     <= lo_prod_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        value_reg       <= value_next;
        result_reg      <= result_next;
        outcome_reg     <= outcome_next;
        upd_reg         <= upd_next;
        rsp_result_reg  <= rsp_result_next;
        rsp_outcome_reg <= rsp_outcome_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/dct_checker.sv
// port-level checks of the decayed count table and their bind
`default_nettype none

`include "assert_macros.svh"

module dct_checker import dct_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cmd_valid,
    input wire logic                 cmd_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [DATA_W-1:0]    rsp_entry_result,
    input wire logic [OUTCOME_W-1:0] rsp_outcome
);

    logic       cmd_fire;
    logic       rsp_fire;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // words taken but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + {1'b0, cmd_fire} - {1'b0, rsp_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `DCT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_result) && $stable(rsp_outcome), "result word changed while stalled")
    `DCT_ASSERT_NXT(a_busy_after_take, cmd_fire, !cmd_ready, "second word taken while busy")
    `DCT_ASSERT_IMP(a_rsp_has_cmd, rsp_valid, inflight_reg != 2'd0, "result without a taken word")
    `DCT_ASSERT_IMP(a_take_limit, cmd_fire, inflight_reg <= 2'd1, "too many words in flight")

endmodule

bind decayed_count_table dct_checker u_dct_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_entry_result (rsp.entry_result),
    .rsp_outcome      (rsp.outcome)
);

`default_nettype wire
